[hdl/owm_pkg.sv]
`timescale 1ns / 1ps

package owm_pkg;

  // Command codes carried in the input tuser field.
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_RESET = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_TEMP  = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] REG_PRESENCE_TAIL = 3'd2;
  localparam logic [2:0] REG_SLOT_LONG     = 3'd3;
  localparam logic [2:0] REG_SLOT_SHORT    = 3'd4;
  localparam logic [2:0] REG_READ_SAMPLE   = 3'd5;
  localparam logic [2:0] REG_READ_TAIL     = 3'd6;

  // Steps of the temperature read sequence; zero means a single command.
  localparam logic [3:0] SEQ_SINGLE = 4'd0;
  localparam logic [3:0] SEQ_RST1   = 4'd1;
  localparam logic [3:0] SEQ_SKIP1  = 4'd2;
  localparam logic [3:0] SEQ_CONV   = 4'd3;
  localparam logic [3:0] SEQ_RST2   = 4'd4;
  localparam logic [3:0] SEQ_SKIP2  = 4'd5;
  localparam logic [3:0] SEQ_RDSP   = 4'd6;
  localparam logic [3:0] SEQ_RDLO   = 4'd7;
  localparam logic [3:0] SEQ_RDHI   = 4'd8;

  // Bus command bytes and the error temperature.
  localparam logic [7:0]  ROM_SKIP     = 8'hCC;
  localparam logic [7:0]  FN_CONVERT   = 8'h44;
  localparam logic [7:0]  FN_READ_PAD  = 8'hBE;
  localparam logic [15:0] TEMP_ERR_VAL = 16'h7FFF;

  localparam int TMR_W = 10;

  // A programmed duration of zero still lasts one tick.
  function automatic logic [TMR_W-1:0] dur(input logic [TMR_W-1:0] t);
    dur = (t == '0) ? TMR_W'(1) : t;
  endfunction

endpackage

[hdl/owm_skid.sv]
`timescale 1ns / 1ps

module owm_skid #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             skid_valid;
  logic [WIDTH-1:0] skid_data;

  // The spare slot lets one word in while the output word is stalled.
  assign in_ready = !skid_valid;

  // Output register and skid register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && in_ready) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_valid && in_ready) begin
      skid_data <= in_data;
    end
  end

endmodule

[hdl/onewire_master_temperature_read.sv]
`timescale 1ns / 1ps

// One-wire bus master, advanced by one input word per microsecond tick.
// Input stream: s_tuser holds the command (tick only, reset, write byte, read
// byte, read temperature); s_tdata holds the byte to write and the sampled
// bus level. Every accepted word updates the bus state and produces exactly
// one output word: the pull-low drive for the line, busy, a done pulse, the
// presence status, the last read byte, the raw Q12.4 temperature and the
// temperature error flag. Commands that arrive while busy are ignored.
// The tick logic sits between the state registers and a two-entry output
// buffer, so one word is accepted every cycle while the receiver keeps up,
// and its result word is registered into that buffer. When the receiver
// stalls, one more word is taken into the spare buffer entry and s_tready
// then drops until the output drains; no word is lost or repeated.
// Timing registers are written through cfg_we/cfg_index/cfg_data; an index
// past the last register is ignored. Reset (rst, synchronous) returns the
// bus state to idle, clears the held results and loads the default timings.

module onewire_master_temperature_read
  import owm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  // Input words.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] data_byte, [8] line_level, rest zero
  input  logic [2:0]  s_tuser,   // [2:0] cmd
  // Result words.
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] drive_low, [1] busy_res, [2] done_res, [3] no_presence,
  // [11:4] read_data, [27:12] temperature_raw, [28] temp_error, rest zero
  output logic [31:0] m_tdata
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_TAIL,
    PH_WR_A, PH_WR_B, PH_RD_LOW, PH_RD_WAIT, PH_RD_TAIL
  } phase_t;

  // Timing registers.
  logic [9:0] reset_low_time;
  logic [7:0] presence_wait_time;
  logic [9:0] presence_tail_time;
  logic [7:0] slot_long_time;
  logic [3:0] slot_short_time;
  logic [5:0] read_sample_time;
  logic [7:0] read_tail_time;

  // Bus state.
  phase_t      phase, phase_next;
  logic [9:0]  tick_timer, tick_timer_next;
  logic [2:0]  bit_count, bit_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [3:0]  sequence_step, sequence_step_next;
  logic [7:0]  low_temp_byte, low_temp_byte_next;
  logic        presence_flag, presence_flag_next;
  logic [7:0]  last_read, last_read_next;
  logic [15:0] last_temperature, last_temperature_next;
  logic        err_flag, err_flag_next;

  logic        s_accept;
  logic [2:0]  cmd;
  logic [7:0]  data_byte;
  logic        line_level;
  logic        busy_c, drive_c, done_c, complete, was_read;
  logic        res_ready;
  logic [31:0] res_word;

  assign cmd        = s_tuser;
  assign data_byte  = s_tdata[7:0];
  assign line_level = s_tdata[8];
  assign s_accept   = s_tvalid && s_tready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_time     <= 10'd500;
      presence_wait_time <= 8'd60;
      presence_tail_time <= 10'd180;
      slot_long_time     <= 8'd60;
      slot_short_time    <= 4'd2;
      read_sample_time   <= 6'd12;
      read_tail_time     <= 8'd50;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESET_LOW:     reset_low_time     <= cfg_data;
        REG_PRESENCE_WAIT: presence_wait_time <= cfg_data[7:0];
        REG_PRESENCE_TAIL: presence_tail_time <= cfg_data;
        REG_SLOT_LONG:     slot_long_time     <= cfg_data[7:0];
        REG_SLOT_SHORT:    slot_short_time    <= cfg_data[3:0];
        REG_READ_SAMPLE:   read_sample_time   <= cfg_data[5:0];
        REG_READ_TAIL:     read_tail_time     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // One tick of the bus sequencer.
  always_comb begin
    phase_next            = phase;
    tick_timer_next       = tick_timer;
    bit_count_next        = bit_count;
    shift_byte_next       = shift_byte;
    sequence_step_next    = sequence_step;
    low_temp_byte_next    = low_temp_byte;
    presence_flag_next    = presence_flag;
    last_read_next        = last_read;
    last_temperature_next = last_temperature;
    err_flag_next         = err_flag;
    done_c                = 1'b0;
    complete              = 1'b0;
    was_read              = 1'b0;

    // Command start on an idle tick.
    if (phase == PH_IDLE) begin
      unique case (cmd)
        CMD_RESET: begin
          sequence_step_next = SEQ_SINGLE;
          phase_next         = PH_RST_LOW;
          tick_timer_next    = dur(reset_low_time);
        end
        CMD_WRITE: begin
          sequence_step_next = SEQ_SINGLE;
          shift_byte_next    = data_byte;
          bit_count_next     = '0;
          phase_next         = PH_WR_A;
          tick_timer_next    = dur(data_byte[0] ? 10'(slot_short_time)
                                                : 10'(slot_long_time));
        end
        CMD_READ: begin
          sequence_step_next = SEQ_SINGLE;
          shift_byte_next    = '0;
          bit_count_next     = '0;
          phase_next         = PH_RD_LOW;
          tick_timer_next    = dur(10'(slot_short_time));
        end
        CMD_TEMP: begin
          sequence_step_next = SEQ_RST1;
          err_flag_next      = 1'b0;
          phase_next         = PH_RST_LOW;
          tick_timer_next    = dur(reset_low_time);
        end
        default: ;
      endcase
    end

    busy_c  = (phase_next != PH_IDLE);
    drive_c = (phase_next == PH_RST_LOW) || (phase_next == PH_WR_A) ||
              (phase_next == PH_RD_LOW);

    // Slot timing and phase changes.
    if (busy_c) begin
      if (tick_timer_next > 10'd1) begin
        tick_timer_next = tick_timer_next - 10'd1;
      end else begin
        unique case (phase_next)
          PH_RST_LOW: begin
            phase_next      = PH_RST_WAIT;
            tick_timer_next = dur(10'(presence_wait_time));
          end
          PH_RST_WAIT: begin
            presence_flag_next = line_level;
            phase_next         = PH_RST_TAIL;
            tick_timer_next    = dur(presence_tail_time);
          end
          PH_RST_TAIL: complete = 1'b1;
          PH_WR_A: begin
            phase_next      = PH_WR_B;
            tick_timer_next = dur(shift_byte_next[0] ? 10'(slot_long_time)
                                                     : 10'(slot_short_time));
          end
          PH_WR_B: begin
            shift_byte_next = {1'b0, shift_byte_next[7:1]};
            if (bit_count_next == 3'd7) begin
              complete = 1'b1;
            end else begin
              bit_count_next  = bit_count_next + 3'd1;
              phase_next      = PH_WR_A;
              tick_timer_next = dur(shift_byte_next[0] ? 10'(slot_short_time)
                                                       : 10'(slot_long_time));
            end
          end
          PH_RD_LOW: begin
            phase_next      = PH_RD_WAIT;
            tick_timer_next = dur(10'(read_sample_time));
          end
          PH_RD_WAIT: begin
            shift_byte_next = {line_level, shift_byte_next[7:1]};
            phase_next      = PH_RD_TAIL;
            tick_timer_next = dur(10'(read_tail_time));
          end
          PH_RD_TAIL: begin
            if (bit_count_next == 3'd7) begin
              complete = 1'b1;
              was_read = 1'b1;
            end else begin
              bit_count_next  = bit_count_next + 3'd1;
              phase_next      = PH_RD_LOW;
              tick_timer_next = dur(10'(slot_short_time));
            end
          end
          default: begin
            phase_next         = PH_IDLE;
            sequence_step_next = SEQ_SINGLE;
            tick_timer_next    = '0;
            done_c             = 1'b1;
          end
        endcase
      end
    end

    // End of one reset or byte: finish, or move to the next sequence step.
    if (complete) begin
      unique case (sequence_step_next) inside
        SEQ_SINGLE: begin
          if (was_read) last_read_next = shift_byte_next;
          phase_next      = PH_IDLE;
          tick_timer_next = '0;
          done_c          = 1'b1;
        end
        SEQ_RST1, SEQ_RST2: begin
          if (presence_flag_next) begin
            last_temperature_next = TEMP_ERR_VAL;
            err_flag_next         = 1'b1;
            phase_next            = PH_IDLE;
            sequence_step_next    = SEQ_SINGLE;
            tick_timer_next       = '0;
            done_c                = 1'b1;
          end else begin
            sequence_step_next = sequence_step_next + 4'd1;
            shift_byte_next    = ROM_SKIP;
            bit_count_next     = '0;
            phase_next         = PH_WR_A;
            tick_timer_next    = dur(ROM_SKIP[0] ? 10'(slot_short_time)
                                                 : 10'(slot_long_time));
          end
        end
        SEQ_SKIP1, SEQ_SKIP2: begin
          shift_byte_next    = (sequence_step_next == SEQ_SKIP1) ? FN_CONVERT
                                                                 : FN_READ_PAD;
          sequence_step_next = sequence_step_next + 4'd1;
          bit_count_next     = '0;
          phase_next         = PH_WR_A;
          tick_timer_next    = dur(shift_byte_next[0] ? 10'(slot_short_time)
                                                      : 10'(slot_long_time));
        end
        SEQ_CONV: begin
          sequence_step_next = SEQ_RST2;
          phase_next         = PH_RST_LOW;
          tick_timer_next    = dur(reset_low_time);
        end
        SEQ_RDSP, SEQ_RDLO: begin
          if (sequence_step_next == SEQ_RDLO) low_temp_byte_next = shift_byte_next;
          sequence_step_next = sequence_step_next + 4'd1;
          shift_byte_next    = '0;
          bit_count_next     = '0;
          phase_next         = PH_RD_LOW;
          tick_timer_next    = dur(10'(slot_short_time));
        end
        SEQ_RDHI: begin
          last_temperature_next = {shift_byte_next, low_temp_byte_next};
          phase_next            = PH_IDLE;
          sequence_step_next    = SEQ_SINGLE;
          tick_timer_next       = '0;
          done_c                = 1'b1;
        end
        default: begin
          phase_next         = PH_IDLE;
          sequence_step_next = SEQ_SINGLE;
          tick_timer_next    = '0;
          done_c             = 1'b1;
        end
      endcase
    end
  end

  // State advances once per accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      tick_timer       <= '0;
      bit_count        <= '0;
      shift_byte       <= '0;
      sequence_step    <= SEQ_SINGLE;
      low_temp_byte    <= '0;
      presence_flag    <= 1'b0;
      last_read        <= '0;
      last_temperature <= '0;
      err_flag         <= 1'b0;
    end else if (s_accept) begin
      phase            <= phase_next;
      tick_timer       <= tick_timer_next;
      bit_count        <= bit_count_next;
      shift_byte       <= shift_byte_next;
      sequence_step    <= sequence_step_next;
      low_temp_byte    <= low_temp_byte_next;
      presence_flag    <= presence_flag_next;
      last_read        <= last_read_next;
      last_temperature <= last_temperature_next;
      err_flag         <= err_flag_next;
    end
  end

  // Result word packing.
  assign res_word = {3'b000, err_flag_next, last_temperature_next, last_read_next,
                     presence_flag_next, done_c, busy_c, drive_c};

  owm_skid #(
    .WIDTH(32)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (res_ready),
    .in_data  (res_word),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (m_tdata)
  );

  assign s_tready = res_ready;

  // An idle sequencer always has a cleared timer.
  a_idle_timer: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (tick_timer == '0))
    else $error("timer not cleared while idle");

  // A done word always marks a busy tick and leaves the sequencer idle.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    (s_accept && done_c) |-> busy_c)
    else $error("done reported on a non-busy tick");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (s_accept && done_c) |=> (phase == PH_IDLE))
    else $error("sequencer not idle after done");

  // Input is refused only while a result word is held at the output.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

endmodule
